FILE: rtl/hm_pkg.sv
// ----------------------------------------------------------------------------
// hm_pkg: shared types and constants of the heightmap mesher
// Pixel layout, register indexes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package hm_pkg;

  localparam int unsigned MAX_WIDTH = 4096;
  localparam int unsigned ADDR_W    = $clog2(MAX_WIDTH);
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CIDX_W    = 4;
  localparam int unsigned COORD_W   = 12;
  localparam int unsigned HGT_W     = 16;
  localparam int unsigned COL_W     = 8;
  localparam int unsigned NRM_W     = 16;
  localparam int unsigned NRMY_W    = 15;
  localparam int unsigned PIX_W     = HGT_W + 4 * COL_W;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 15;
  localparam int unsigned VERTS      = 6;

  localparam logic [CFG_W-1:0] GRID_RESET = CFG_W'(256);
  localparam logic [CFG_W-1:0] GRID_MIN   = CFG_W'(2);
  localparam logic [CFG_W-1:0] GRID_MAX   = CFG_W'(4096);
  localparam logic [NRM_W-1:0] NRM_ONE    = NRM_W'(16384);

  localparam logic [CIDX_W-1:0] REG_GRID_WIDTH  = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_GRID_HEIGHT = CIDX_W'(1);

  typedef struct packed {
    logic [COL_W-1:0] alpha;
    logic [COL_W-1:0] blue;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] red;
    logic [HGT_W-1:0] height;
  } pixel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_LENGTH,
    ST_SQRT,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_DIV_STORE,
    ST_EMIT,
    ST_COMMIT
  } ctrl_state_e;

  typedef struct packed {
    logic       pix_load;
    logic       above_load;
    logic       sq_load;
    logic       norm_sel;
    logic       len_load;
    logic       sqrt_step;
    logic       div_load;
    logic [1:0] comp_sel;
    logic       div_step;
    logic       div_store;
    logic       vtx_load;
    logic [2:0] vtx_sel;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic out_busy;
  } sts_t;

endpackage

FILE: rtl/hm_ifs.sv
// ----------------------------------------------------------------------------
// hm_ifs: channel interfaces of the heightmap mesher
// Pixel input, vertex output and configuration write channels.
// ----------------------------------------------------------------------------
interface hm_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] height_in;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic [7:0]  alpha_in;
  modport source (output valid, height_in, red_in, green_in, blue_in, alpha_in,
                  input ready);
  modport sink   (input valid, height_in, red_in, green_in, blue_in, alpha_in,
                  output ready);
endinterface

interface hm_vtx_if;
  logic               valid;
  logic               ready;
  logic [11:0]        pos_x;
  logic [11:0]        pos_z;
  logic [15:0]        pos_height;
  logic signed [15:0] norm_x;
  logic [14:0]        norm_y;
  logic signed [15:0] norm_z;
  logic [7:0]         red_out;
  logic [7:0]         green_out;
  logic [7:0]         blue_out;
  logic [7:0]         alpha_out;
  logic               cell_end;
  logic               frame_end;
  modport source (output valid, pos_x, pos_z, pos_height, norm_x, norm_y, norm_z,
                  red_out, green_out, blue_out, alpha_out, cell_end, frame_end,
                  input ready);
  modport sink   (input valid, pos_x, pos_z, pos_height, norm_x, norm_y, norm_z,
                  red_out, green_out, blue_out, alpha_out, cell_end, frame_end,
                  output ready);
endinterface

interface hm_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/hm_ram.sv
// ----------------------------------------------------------------------------
// hm_ram: generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module hm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

FILE: rtl/hm_ctrl.sv
// ----------------------------------------------------------------------------
// hm_ctrl: sequencer of the heightmap mesher
// Steps one pixel through read, then for a cell pixel two normal computations and emit, then commit.
// ----------------------------------------------------------------------------
module hm_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         pix_valid_i,
  output logic         pix_ready_o,
  input  hm_pkg::sts_t sts_i,
  output hm_pkg::cmd_t cmd_o
);
  import hm_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [4:0]  step_q, step_d;
  logic [1:0]  comp_q, comp_d;
  logic        norm_q, norm_d;
  logic [2:0]  vtx_q, vtx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      comp_q  <= '0;
      norm_q  <= 1'b0;
      vtx_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      comp_q  <= comp_d;
      norm_q  <= norm_d;
      vtx_q   <= vtx_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    comp_d      = comp_q;
    norm_d      = norm_q;
    vtx_d       = vtx_q;
    pix_ready_o = 1'b0;
    cmd_o          = '0;
    cmd_o.norm_sel = norm_q;
    cmd_o.comp_sel = comp_q;
    cmd_o.vtx_sel  = vtx_q;
    unique case (state_q)
      ST_IDLE: begin
        pix_ready_o = 1'b1;
        if (pix_valid_i) begin
          cmd_o.pix_load = 1'b1;
          state_d        = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.above_load = 1'b1;
        norm_d           = 1'b0;
        state_d          = sts_i.emit ? ST_SQUARE : ST_COMMIT;
      end
      ST_SQUARE: begin
        cmd_o.sq_load = 1'b1;
        state_d       = ST_LENGTH;
      end
      ST_LENGTH: begin
        cmd_o.len_load = 1'b1;
        step_d         = '0;
        state_d        = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        step_d          = step_q + 5'd1;
        if (step_q == 5'(SQRT_STEPS - 1)) begin
          comp_d  = '0;
          state_d = ST_DIV_LOAD;
        end
      end
      ST_DIV_LOAD: begin
        cmd_o.div_load = 1'b1;
        step_d         = '0;
        state_d        = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 5'd1;
        if (step_q == 5'(DIV_STEPS - 1)) begin
          state_d = ST_DIV_STORE;
        end
      end
      ST_DIV_STORE: begin
        cmd_o.div_store = 1'b1;
        if (comp_q == 2'd2) begin
          if (!norm_q) begin
            norm_d  = 1'b1;
            state_d = ST_SQUARE;
          end else begin
            vtx_d   = '0;
            state_d = ST_EMIT;
          end
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ST_DIV_LOAD;
        end
      end
      ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.vtx_load = 1'b1;
          vtx_d          = vtx_q + 3'd1;
          if (vtx_q == 3'(VERTS - 1)) begin
            state_d = ST_COMMIT;
          end
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/hm_dp.sv
// ----------------------------------------------------------------------------
// hm_dp: datapath of the heightmap mesher
// Line store, neighbor registers, counters, bit-serial square root,
// restoring divider and the vertex output register.
// ----------------------------------------------------------------------------
module hm_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hm_pkg::cmd_t              cmd_i,
  output hm_pkg::sts_t              sts_o,
  input  hm_pkg::pixel_t            pix_i,
  input  logic                      cfg_we_i,
  input  logic [hm_pkg::CIDX_W-1:0] cfg_index_i,
  input  logic [hm_pkg::CFG_W-1:0]  cfg_data_i,
  hm_vtx_if.source                  vtx_o
);
  import hm_pkg::*;

  // configuration
  logic [CFG_W-1:0] grid_w_q, grid_h_q, w_eff, h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= GRID_RESET;
      grid_h_q <= GRID_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_GRID_WIDTH)  grid_w_q <= cfg_data_i;
      if (cfg_index_i == REG_GRID_HEIGHT) grid_h_q <= cfg_data_i;
    end
  end

  always_comb begin
    w_eff = grid_w_q;
    if (grid_w_q < GRID_MIN) w_eff = GRID_MIN;
    if (grid_w_q > GRID_MAX) w_eff = GRID_MAX;
    h_eff = grid_h_q;
    if (grid_h_q < GRID_MIN) h_eff = GRID_MIN;
    if (grid_h_q > GRID_MAX) h_eff = GRID_MAX;
  end

  // position and neighbors
  logic [COORD_W-1:0] x_q, z_q;
  pixel_t             cur_q, above_q, left_q, ul_q;
  pixel_t             ram_rdata;
  logic               last_col, last_row;

  assign last_col   = ({1'b0, x_q} + CFG_W'(1)) >= w_eff;
  assign last_row   = ({1'b0, z_q} + CFG_W'(1)) >= h_eff;
  assign sts_o.emit = (x_q != '0) && (z_q != '0);

  hm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .addr_i  (x_q[ADDR_W-1:0]),
    .wdata_i (cur_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_load)   cur_q   <= pix_i;
    if (cmd_i.above_load) above_q <= ram_rdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      z_q    <= '0;
      left_q <= '0;
      ul_q   <= '0;
    end else if (cmd_i.commit) begin
      ul_q   <= above_q;
      left_q <= cur_q;
      if (last_col) begin
        x_q <= '0;
        z_q <= last_row ? '0 : z_q + COORD_W'(1);
      end else begin
        x_q <= x_q + COORD_W'(1);
      end
    end
  end

  // squares of the two difference components
  logic signed [HGT_W:0] dx, dz;
  logic [HGT_W-1:0]      dx_mag_q, dz_mag_q, dx_mag, dz_mag;
  logic                  dx_neg_q, dz_neg_q;
  logic [2*HGT_W-1:0]    dx_sq_q, dz_sq_q;

  always_comb begin
    if (!cmd_i.norm_sel) begin
      dx = $signed({1'b0, ul_q.height})   - $signed({1'b0, above_q.height});
      dz = $signed({1'b0, above_q.height}) - $signed({1'b0, cur_q.height});
    end else begin
      dx = $signed({1'b0, left_q.height}) - $signed({1'b0, cur_q.height});
      dz = $signed({1'b0, ul_q.height})   - $signed({1'b0, left_q.height});
    end
    dx_mag = dx[HGT_W] ? HGT_W'(-dx) : dx[HGT_W-1:0];
    dz_mag = dz[HGT_W] ? HGT_W'(-dz) : dz[HGT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_load) begin
      dx_mag_q <= dx_mag;
      dz_mag_q <= dz_mag;
      dx_neg_q <= dx[HGT_W];
      dz_neg_q <= dz[HGT_W];
      dx_sq_q  <= dx_mag * dx_mag;
      dz_sq_q  <= dz_mag * dz_mag;
    end
  end

  // bit-serial integer square root of length squared times 2^28
  logic [63:0] sq_v_q, sq_res_q, sq_bit_q, sq_try;
  logic [33:0] len_sq;
  logic [31:0] root;

  assign len_sq = 34'(dx_sq_q) + 34'(dz_sq_q) + 34'd65536;
  assign sq_try = sq_res_q + sq_bit_q;
  assign root   = sq_res_q[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.len_load) begin
      sq_v_q   <= {2'b00, len_sq, 28'd0};
      sq_res_q <= '0;
      sq_bit_q <= 64'd1 << 62;
    end else if (cmd_i.sqrt_step) begin
      if (sq_v_q >= sq_try) begin
        sq_v_q   <= sq_v_q - sq_try;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
  end

  // restoring divider, rounded quotient saturated to one
  logic [HGT_W-1:0]    mag;
  logic                neg;
  logic [45:0]         num, rem_q, dsh_q;
  logic [DIV_STEPS-1:0] quo_q;
  logic                sat_q, neg_q;
  logic [NRM_W-1:0]    q_clamp, q_signed;

  always_comb begin
    unique case (cmd_i.comp_sel)
      2'd0:    begin mag = dx_mag_q;      neg = dx_neg_q; end
      2'd1:    begin mag = HGT_W'(256);   neg = 1'b0;     end
      default: begin mag = dz_mag_q;      neg = dz_neg_q; end
    endcase
    num = {2'b00, mag, 28'd0} + 46'(root >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= num;
      dsh_q <= {root, 14'd0};
      sat_q <= num >= {root[30:0], 15'd0} || root[31];
      neg_q <= neg;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[DIV_STEPS-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[DIV_STEPS-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  assign q_clamp  = (sat_q || {1'b0, quo_q} > NRM_ONE) ? NRM_ONE : {1'b0, quo_q};
  assign q_signed = neg_q ? NRM_W'(-q_clamp) : q_clamp;

  logic [NRM_W-1:0] nrm_q [2][3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_store) begin
      nrm_q[cmd_i.norm_sel][cmd_i.comp_sel] <= q_signed;
    end
  end

  // vertex output register
  logic               out_valid_q;
  logic [COORD_W-1:0] vx, vz, x0, z0;
  pixel_t             vpix;
  logic               vn;

  assign x0 = x_q - COORD_W'(1);
  assign z0 = z_q - COORD_W'(1);
  assign sts_o.out_busy = out_valid_q && !vtx_o.ready;
  assign vtx_o.valid    = out_valid_q;

  always_comb begin
    unique case (cmd_i.vtx_sel)
      3'd0:    begin vx = x0;  vz = z0;  vpix = ul_q;    vn = 1'b0; end
      3'd1:    begin vx = x_q; vz = z_q; vpix = cur_q;   vn = 1'b0; end
      3'd2:    begin vx = x_q; vz = z0;  vpix = above_q; vn = 1'b0; end
      3'd3:    begin vx = x_q; vz = z_q; vpix = cur_q;   vn = 1'b1; end
      3'd4:    begin vx = x0;  vz = z0;  vpix = ul_q;    vn = 1'b1; end
      default: begin vx = x0;  vz = z_q; vpix = left_q;  vn = 1'b1; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.vtx_load) begin
      out_valid_q <= 1'b1;
    end else if (vtx_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.vtx_load) begin
      vtx_o.pos_x      <= vx;
      vtx_o.pos_z      <= vz;
      vtx_o.pos_height <= vpix.height;
      vtx_o.norm_x     <= nrm_q[vn][0];
      vtx_o.norm_y     <= nrm_q[vn][1][NRMY_W-1:0];
      vtx_o.norm_z     <= nrm_q[vn][2];
      vtx_o.red_out    <= vpix.red;
      vtx_o.green_out  <= vpix.green;
      vtx_o.blue_out   <= vpix.blue;
      vtx_o.alpha_out  <= vpix.alpha;
      vtx_o.cell_end   <= cmd_i.vtx_sel == 3'(VERTS - 1);
      vtx_o.frame_end  <= cmd_i.vtx_sel == 3'(VERTS - 1) && last_col && last_row;
    end
  end

endmodule

FILE: rtl/heightmap_mesh_with_normals.sv
// ----------------------------------------------------------------------------
// heightmap_mesh_with_normals: terrain triangulation with face normals
// Turns raster-order heightmap and color pixels into triangle vertices.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order on pix_i, one transfer each. The previous row
// sits in a 4096-entry line store and the left and upper-left pixels in
// registers. Every pixel at column > 0 and row > 0 closes a grid cell and
// yields six vertices on vtx_o: h00, h11, h10 for the first triangle, then
// h11, h00, h01 for the second, each with grid position, Q8.8 height, color
// and the Q1.14 unit normal of its triangle; cell_end marks the sixth vertex
// and frame_end the sixth vertex of the last cell of the frame. An edge pixel
// goes from read straight to commit. The time of a cell pixel is set by one
// shared bit-serial square root and one restoring divider, used for two
// normals of three components each, then by emitting its six vertices, plus
// any output stall. The last vertex waits in the output register while the
// next pixel is taken. Write grid_width (index 0) and grid_height (index 1)
// on cfg_i only between frames while idle; values are clamped to 2..4096. The
// line store is never cleared; the first row of each frame fills it before it
// is read.
// ----------------------------------------------------------------------------
module heightmap_mesh_with_normals (
  input logic      clk_i,
  input logic      rst_ni,
  hm_pix_if.sink   pix_i,
  hm_cfg_if.sink   cfg_i,
  hm_vtx_if.source vtx_o
);
  import hm_pkg::*;

  cmd_t   cmd;
  sts_t   sts;
  pixel_t pix;

  // always take configuration writes
  assign cfg_i.ready = 1'b1;

  // pack the pixel payload
  assign pix.height = pix_i.height_in;
  assign pix.red    = pix_i.red_in;
  assign pix.green  = pix_i.green_in;
  assign pix.blue   = pix_i.blue_in;
  assign pix.alpha  = pix_i.alpha_in;

  hm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_i.valid),
    .pix_ready_o (pix_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .pix_i       (pix),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .vtx_o       (vtx_o)
  );

endmodule

FILE: rtl/hm_checker.sv
// ----------------------------------------------------------------------------
// hm_checker: port-level checks of the heightmap mesher
// Watches the vertex channel and flags malformed results.
// ----------------------------------------------------------------------------
module hm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               vtx_valid,
  input logic               vtx_ready,
  input logic [11:0]        pos_x,
  input logic signed [15:0] norm_x,
  input logic [14:0]        norm_y,
  input logic signed [15:0] norm_z,
  input logic               cell_end,
  input logic               frame_end
);

  // hold a stalled vertex
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_valid && !vtx_ready |=> vtx_valid && $stable(pos_x) && $stable(norm_x))
    else $error("stalled vertex changed");

  // frame end only closes a cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_valid && frame_end |-> cell_end)
    else $error("frame_end without cell_end");

  // y component is positive and at most one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_valid |-> norm_y != 15'd0 && norm_y <= 15'd16384)
    else $error("norm_y out of range");

  // x and z components stay within unit range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_valid |-> norm_x >= -16'sd16384 && norm_x <= 16'sd16384 &&
                  norm_z >= -16'sd16384 && norm_z <= 16'sd16384)
    else $error("normal component out of range");

endmodule

bind heightmap_mesh_with_normals hm_checker u_hm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .vtx_valid (vtx_o.valid),
  .vtx_ready (vtx_o.ready),
  .pos_x     (vtx_o.pos_x),
  .norm_x    (vtx_o.norm_x),
  .norm_y    (vtx_o.norm_y),
  .norm_z    (vtx_o.norm_z),
  .cell_end  (vtx_o.cell_end),
  .frame_end (vtx_o.frame_end)
);
